FILE: rtl/kcl_pkg.sv
// ============================================================================
// kcl_pkg
// Shared types and constants for the keypad code lock: key codes, event
// codes, the lock mode, the result word and the power-on password.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

    // Key codes of the letters used as default close and change keys.
    localparam logic [3:0] KEY_A = 4'd10;
    localparam logic [3:0] KEY_D = 4'd13;

    // Configuration register indexes.
    localparam logic CFG_CLOSE_KEY  = 1'b0;
    localparam logic CFG_CHANGE_KEY = 1'b1;

    // Key code for each matrix bit, bit = column*4 + row.
    localparam logic [3:0] KEY_OF_BIT [16] = '{
        4'd1,  4'd4,  4'd7,  4'd14,
        4'd2,  4'd5,  4'd8,  4'd0,
        4'd3,  4'd6,  4'd9,  4'd15,
        4'd10, 4'd11, 4'd12, 4'd13
    };

    // Event reported with each result word.
    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_DIGIT    = 4'd1,
        EV_OPENED   = 4'd2,
        EV_WRONG    = 4'd3,
        EV_CHSTART  = 4'd4,
        EV_CLOSED   = 4'd5,
        EV_NEWDIGIT = 4'd6,
        EV_CHANGED  = 4'd7,
        EV_IGNORED  = 4'd8
    } event_t;

    // Lock mode: changing implies the door is open.
    typedef enum logic [1:0] {
        MODE_LOCKED,
        MODE_OPEN,
        MODE_CHANGING
    } mode_t;

    // One result word.
    typedef struct packed {
        logic       key_valid;
        logic [3:0] key_code;
        event_t     event_res;
        logic       door_open;
        logic       changing_password;
        logic [2:0] digits_entered;
    } result_t;

    // Power-on password 1,2,2,4,5,5; positions past the sixth are zero.
    function automatic logic [3:0] pw_reset(input logic [3:0] pos);
        logic [3:0] key;
        case (pos)
            4'd0:    key = 4'd1;
            4'd1:    key = 4'd2;
            4'd2:    key = 4'd2;
            4'd3:    key = 4'd4;
            4'd4:    key = 4'd5;
            4'd5:    key = 4'd5;
            default: key = 4'd0;
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/kcl_key_scan.sv
// ============================================================================
// kcl_key_scan
// Priority encoder for one keypad matrix sample: the lowest set bit wins,
// so column 0 beats column 1 and, within a column, row 0 beats row 1.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kcl_key_scan (
    input  wire logic [15:0] key_matrix,
    output logic             key_down,
    output logic [3:0]       key_code
);

    // Any pressed key at all.
    assign key_down = |key_matrix;

    // Walk from the highest bit down so the lowest set bit is written last.
    always_comb begin
        key_code = 4'd0;
        for (int b = 15; b >= 0; b--) begin
            if (key_matrix[b]) begin
                key_code = kcl_pkg::KEY_OF_BIT[b];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kcl_lock_core.sv
// ============================================================================
// kcl_lock_core
// Lock state machine: press edge detection, code entry with a parallel
// compare against the stored password, door open/close and password change.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module kcl_lock_core #(
    parameter int CODE_LENGTH = 6
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire logic            key_down,
    input  wire logic [3:0]      key_code,
    input  wire logic [3:0]      close_key,
    input  wire logic [3:0]      change_key,
    output kcl_pkg::result_t     res
);

    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LENGTH - 1);

    kcl_pkg::mode_t   mode_reg;
    kcl_pkg::mode_t   mode_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             key_was_down_reg;
    logic [3:0]       entry_reg [CODE_LENGTH];
    logic [3:0]       pw_reg    [CODE_LENGTH];

    logic             key_valid;
    logic             last_digit;
    logic             entry_we;
    logic             pw_we;
    logic             code_match;
    logic [CODE_LENGTH-1:0] pos_eq;
    kcl_pkg::event_t  ev;

    // Per-position compare; the final position uses the key being entered now.
    for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_cmp
        if (i == CODE_LENGTH - 1) begin : g_last
            assign pos_eq[i] = (key_code == pw_reg[i]);
        end else begin : g_prev
            assign pos_eq[i] = (entry_reg[i] == pw_reg[i]);
        end
    end
    assign code_match = &pos_eq;

    // Next state, store write enables and the result word.
    always_comb begin
        key_valid  = key_down && !key_was_down_reg;
        last_digit = (idx_reg == LAST_IDX);
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        ev         = kcl_pkg::EV_NONE;
        entry_we   = 1'b0;
        pw_we      = 1'b0;
        if (key_valid) begin
            case (mode_reg)
                kcl_pkg::MODE_LOCKED: begin
                    entry_we = 1'b1;
                    if (last_digit) begin
                        idx_next = '0;
                        if (code_match) begin
                            mode_next = kcl_pkg::MODE_OPEN;
                            ev        = kcl_pkg::EV_OPENED;
                        end else begin
                            ev = kcl_pkg::EV_WRONG;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        ev       = kcl_pkg::EV_DIGIT;
                    end
                end
                kcl_pkg::MODE_OPEN: begin
                    if (key_code == change_key) begin
                        mode_next = kcl_pkg::MODE_CHANGING;
                        ev        = kcl_pkg::EV_CHSTART;
                    end else if (key_code == close_key) begin
                        mode_next = kcl_pkg::MODE_LOCKED;
                        ev        = kcl_pkg::EV_CLOSED;
                    end else begin
                        ev = kcl_pkg::EV_IGNORED;
                    end
                end
                kcl_pkg::MODE_CHANGING: begin
                    pw_we = 1'b1;
                    if (last_digit) begin
                        idx_next  = '0;
                        mode_next = kcl_pkg::MODE_OPEN;
                        ev        = kcl_pkg::EV_CHANGED;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        ev       = kcl_pkg::EV_NEWDIGIT;
                    end
                end
                default: begin
                    mode_next = kcl_pkg::MODE_LOCKED;
                end
            endcase
        end

        res.key_valid         = key_valid;
        res.key_code          = key_valid ? key_code : 4'd0;
        res.event_res         = ev;
        res.door_open         = (mode_next != kcl_pkg::MODE_LOCKED);
        res.changing_password = (mode_next == kcl_pkg::MODE_CHANGING);
        res.digits_entered    = 3'(idx_next);
    end

    // Control state and the stored password.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= kcl_pkg::MODE_LOCKED;
            idx_reg          <= '0;
            key_was_down_reg <= 1'b0;
            for (int i = 0; i < CODE_LENGTH; i++) begin
                pw_reg[i] <= kcl_pkg::pw_reset(4'(i));
            end
        end else if (step_en) begin
            mode_reg         <= mode_next;
            idx_reg          <= idx_next;
            key_was_down_reg <= key_down;
            if (pw_we) begin
                pw_reg[idx_reg] <= key_code;
            end
        end
    end

    // Entered digits; only positions already written this entry are compared.
    always_ff @(posedge aclk) begin
        if (step_en && entry_we) begin
            entry_reg[idx_reg] <= key_code;
        end
    end

    // The digit index never reaches the code length.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_IDX)
        else $error("digit index out of range");

    // With the door open and no change under way, no entry is in progress.
    a_open_idle_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == kcl_pkg::MODE_OPEN) |-> (idx_reg == '0))
        else $error("digit index nonzero while open");

    // A step without a new press leaves the lock state alone.
    a_no_press_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !key_valid) |=> ($stable(mode_reg) && $stable(idx_reg)))
        else $error("lock state changed without a key press");

endmodule

`default_nettype wire

FILE: rtl/keypad_code_lock.sv
// ============================================================================
// keypad_code_lock
// Keypad door code lock: one 4x4 matrix sample in, one result word out.
// ============================================================================
// Usage:
//   s_valid/s_ready carry one keypad matrix sample per word (bit col*4+row).
//   m_valid/m_ready return exactly one result word per sample, in order:
//   key press seen, key code, event, door and change flags, digit count.
//   cfg_valid/cfg_ready write the close key (index 0) or the change key
//   (index 1); cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A sample is held in the input register while the lock logic evaluates
//   it, and its result is then written into the result register.
//   Throughput is one sample per cycle while m_ready is high; the lock state
//   is updated in a single pass from the input to the result register.
// Stall:
//   While m_ready is low the result register holds; one more sample is taken
//   into the input register, then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous):
//   Door locked, no entry in progress, no key held, password 1 2 2 4 5 5,
//   close key A and change key D. Both registers are emptied.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_lock #(
    parameter int CODE_LENGTH = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data,
    // Keypad samples
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_key_matrix,
    // Results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_key_valid,
    output logic [3:0]       m_key_code,
    output logic [3:0]       m_event_res,
    output logic             m_door_open,
    output logic             m_changing_password,
    output logic [2:0]       m_digits_entered
);

    logic              in_valid_reg;
    logic [15:0]       in_matrix_reg;
    logic              out_valid_reg;
    kcl_pkg::result_t  res_reg;
    kcl_pkg::result_t  res;
    logic [3:0]        close_key_reg;
    logic [3:0]        change_key_reg;
    logic              advance;
    logic              key_down;
    logic [3:0]        key_code;

    // The input word moves on when the result register is free or draining.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_key_reg  <= kcl_pkg::KEY_A;
            change_key_reg <= kcl_pkg::KEY_D;
        end else if (cfg_valid) begin
            case (cfg_index)
                kcl_pkg::CFG_CLOSE_KEY:  close_key_reg  <= cfg_data;
                kcl_pkg::CFG_CHANGE_KEY: change_key_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_matrix_reg <= s_key_matrix;
        end
    end

    kcl_key_scan u_scan (
        .key_matrix (in_matrix_reg),
        .key_down   (key_down),
        .key_code   (key_code)
    );

    kcl_lock_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .key_down   (key_down),
        .key_code   (key_code),
        .close_key  (close_key_reg),
        .change_key (change_key_reg),
        .res        (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    // Result ports.
    assign m_valid             = out_valid_reg;
    assign m_key_valid         = res_reg.key_valid;
    assign m_key_code          = res_reg.key_code;
    assign m_event_res         = res_reg.event_res;
    assign m_door_open         = res_reg.door_open;
    assign m_changing_password = res_reg.changing_password;
    assign m_digits_entered    = res_reg.digits_entered;

endmodule

`default_nettype wire
